// ===== rtl/scss_pkg.sv =====
// ----------------------------------------------------------------------------
// scss_pkg
// Shared types and constants of the sign-corrected slope stream.
// ----------------------------------------------------------------------------
package scss_pkg;

  localparam int SLOPE_W     = 27;
  localparam int SLOPE_LIMIT = 67108863;
  localparam int RUN_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int WARM_W      = 3;

  localparam logic [RUN_W-1:0]      RUN_MAX       = 8'd255;
  localparam logic [CFG_IDX_W-1:0]  REG_ORDER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_MIN_RUN    = 2'd1;
  localparam logic [CFG_DATA_W-1:0] MIN_RUN_RESET  = 4'd4;
  localparam logic [WARM_W-1:0]     WARM_DONE      = 3'd4;

  typedef logic signed [SLOPE_W-1:0] slope_t;

  // broadcast to every hold cell
  typedef struct packed {
    logic             flip;
    logic             to_neg;
    logic             shift;
    logic             load;
    logic [RUN_W-1:0] run_len;
  } cell_ctl_t;

endpackage

// ===== rtl/scss_stencil.sv =====
// ----------------------------------------------------------------------------
// scss_stencil
// Four-sample window and five-point stencil, saturated to the slope field.
// ----------------------------------------------------------------------------
module scss_stencil #(
  parameter int SAMPLE_BITS = 20
) (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic                   order_mode,
  input  logic [SAMPLE_BITS-1:0] sample,
  output scss_pkg::slope_t       slope
);

  localparam int DW = (SAMPLE_BITS + 7 > 28) ? SAMPLE_BITS + 7 : 28;

  logic [SAMPLE_BITS-1:0] win_r [4];
  logic signed [DW-1:0]   y, w0, w1, w2, w3, acc;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= win_r[3];
      win_r[3] <= sample;
    end
  end

  always_comb begin
    y  = DW'(sample);
    w0 = DW'(win_r[0]);
    w1 = DW'(win_r[1]);
    w2 = DW'(win_r[2]);
    w3 = DW'(win_r[3]);
    if (order_mode) begin
      acc = (w3 <<< 4) + (w1 <<< 4) - (w2 <<< 5) + (w2 <<< 1) - y - w0;
    end else begin
      acc = (w3 <<< 3) - (w1 <<< 3) + w0 - y;
    end
    if (acc > DW'(scss_pkg::SLOPE_LIMIT)) begin
      slope = scss_pkg::SLOPE_W'(scss_pkg::SLOPE_LIMIT);
    end else if (acc < -DW'(scss_pkg::SLOPE_LIMIT)) begin
      slope = -scss_pkg::SLOPE_W'(scss_pkg::SLOPE_LIMIT);
    end else begin
      slope = acc[scss_pkg::SLOPE_W-1:0];
    end
  end

endmodule

// ===== rtl/scss_cell.sv =====
// ----------------------------------------------------------------------------
// scss_cell
// One hold cell: keeps a value, applies the run flip, shifts toward the head.
// ----------------------------------------------------------------------------
module scss_cell #(
  parameter int CW     = 3,
  parameter int IDX    = 0,
  parameter bit IS_END = 1'b0
) (
  input  logic                clk,
  input  scss_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]       count,
  input  scss_pkg::slope_t    d_in,
  input  scss_pkg::slope_t    nb_in,
  output scss_pkg::slope_t    val_out
);

  localparam logic [CW-1:0] POS = CW'(IDX);

  scss_pkg::slope_t         v_r, v_nxt;
  logic [CW-1:0]            span;
  logic                     flip_here;

  always_comb begin
    span      = count - POS;
    flip_here = ctl.flip && (count > POS) &&
                (scss_pkg::RUN_W'(span) <= ctl.run_len);
    val_out   = v_r;
    if (flip_here) begin
      if (ctl.to_neg) begin
        val_out = -v_r;
      end else if (v_r < 0) begin
        val_out = -v_r;
      end
    end
    if (ctl.shift) begin
      v_nxt = IS_END ? d_in : nb_in;
    end else if (ctl.load && count == POS) begin
      v_nxt = d_in;
    end else begin
      v_nxt = val_out;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

endmodule

// ===== rtl/sign_corrected_slope_stream.sv =====
// ----------------------------------------------------------------------------
// sign_corrected_slope_stream
// Five-point stencil slope with short-run sign correction and crossing flags.
// ----------------------------------------------------------------------------
// One sample is taken per clock while the result side keeps up. From the fifth
// sample of a curve each sample yields a slope, which sits in a row of
// MAX_RUN-1 hold cells until no flip can reach it; a result leaves through a
// single output register once the row is full, so results trail the input by
// MAX_RUN-1 values. On the last sample the held values drain one per cycle
// through the output register while the result side keeps up, and no sample is
// taken during the drain; that drain and the output register set the rate.
module sign_corrected_slope_stream #(
  parameter int MAX_RUN     = 8,
  parameter int SAMPLE_BITS = 20,
  parameter int INDEX_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [scss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [SAMPLE_BITS-1:0]               in_sample,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [INDEX_BITS-1:0]                out_index,
  output logic signed [scss_pkg::SLOPE_W-1:0]  out_slope,
  output logic                                 out_turn_down,
  output logic                                 out_turn_up,
  output logic                                 out_end_of_curve
);

  localparam int HOLD = MAX_RUN - 1;
  localparam int CW   = $clog2(MAX_RUN);
  localparam logic [CW-1:0] HOLD_C = CW'(HOLD);

  logic                               order_mode_r;
  logic [scss_pkg::CFG_DATA_W-1:0]    min_run_r;

  logic [scss_pkg::WARM_W-1:0]        warm_r, warm_nxt;
  logic [CW-1:0]                      cnt_r, cnt_nxt;
  logic                               flush_r, flush_nxt;
  logic                               rp_r, rp_nxt;
  logic [scss_pkg::RUN_W-1:0]         rl_r, rl_nxt, prl_r, prl_nxt;
  logic [scss_pkg::RUN_W-1:0]         min_run_ext, rl_sum, rl_inc;
  scss_pkg::slope_t                   prev_r, prev_nxt;
  logic                               any_r, any_nxt;
  logic [INDEX_BITS-1:0]              idx_r, idx_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [INDEX_BITS-1:0]              out_index_r;
  scss_pkg::slope_t                   out_slope_r;
  logic                               out_down_r, out_up_r, out_end_r;

  logic                               warm, full, slot_free, in_acc, take, pop;
  logic                               neg, pos, emit;
  logic [scss_pkg::RUN_W:0]           sum9, inc9;
  scss_pkg::slope_t                   d, head;
  scss_pkg::cell_ctl_t                ctl;
  scss_pkg::slope_t                   cell_f [HOLD];

  assign warm      = (warm_r == scss_pkg::WARM_DONE);
  assign full      = (cnt_r == HOLD_C);
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = !flush_r && (!(warm && full) || slot_free);
  assign in_acc    = in_valid && in_ready;
  assign take      = in_acc && warm;
  assign pop       = flush_r && slot_free;
  assign emit      = (take && full) || pop;
  assign head      = cell_f[0];

  assign neg         = d[scss_pkg::SLOPE_W-1];
  assign pos         = !neg && (d != '0);
  assign min_run_ext = scss_pkg::RUN_W'(min_run_r);
  assign sum9        = {1'b0, prl_r} + {1'b0, rl_r};
  assign inc9        = {1'b0, rl_r} + 9'd1;
  assign rl_sum      = sum9[scss_pkg::RUN_W] ? scss_pkg::RUN_MAX : sum9[scss_pkg::RUN_W-1:0];
  assign rl_inc      = inc9[scss_pkg::RUN_W] ? scss_pkg::RUN_MAX : inc9[scss_pkg::RUN_W-1:0];

  scss_stencil #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_stencil (
    .clk       (clk),
    .shift_en  (in_acc),
    .order_mode(order_mode_r),
    .sample    (in_sample),
    .slope     (d)
  );

  for (genvar i = 0; i < HOLD; i++) begin : g_cell
    scss_pkg::slope_t nb;
    if (i == HOLD - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_f[i+1];
    end
    scss_cell #(
      .CW    (CW),
      .IDX   (i),
      .IS_END(i == HOLD - 1)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .count  (cnt_r),
      .d_in   (d),
      .nb_in  (nb),
      .val_out(cell_f[i])
    );
  end

  always_comb begin
    ctl         = '0;
    ctl.run_len = rl_r;
    ctl.load    = take;
    ctl.shift   = emit;
    rp_nxt      = rp_r;
    rl_nxt      = rl_r;
    prl_nxt     = prl_r;
    warm_nxt    = warm_r;
    cnt_nxt     = cnt_r;
    flush_nxt   = flush_r;
    prev_nxt    = prev_r;
    any_nxt     = any_r;
    idx_nxt     = idx_r;

    if (take) begin
      if (neg && rp_r && rl_r >= min_run_ext) begin
        rp_nxt  = 1'b0;
        prl_nxt = rl_r;
        rl_nxt  = 8'd1;
      end else if (neg && rp_r) begin
        ctl.flip   = 1'b1;
        ctl.to_neg = 1'b1;
        if (rl_r != '0) begin
          rp_nxt = 1'b0;
        end
        rl_nxt = rl_sum;
      end else if (pos && !rp_r && rl_r < min_run_ext) begin
        ctl.flip = 1'b1;
        if (rl_r != '0) begin
          rp_nxt = 1'b1;
        end
        rl_nxt = rl_sum;
      end else if (pos && !rp_r) begin
        rp_nxt  = 1'b1;
        prl_nxt = rl_r;
        rl_nxt  = 8'd1;
      end else begin
        rl_nxt = rl_inc;
      end
      if (!full) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else if (in_acc) begin
      warm_nxt = warm_r + 1'b1;
    end

    if (in_acc && in_last) begin
      warm_nxt  = '0;
      rp_nxt    = 1'b1;
      rl_nxt    = min_run_ext;
      prl_nxt   = '0;
      flush_nxt = warm;
    end

    if (emit) begin
      prev_nxt = head;
      any_nxt  = 1'b1;
      idx_nxt  = idx_r + 1'b1;
    end

    if (pop) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        flush_nxt = 1'b0;
        prev_nxt  = '0;
        any_nxt   = 1'b0;
        idx_nxt   = '0;
      end
    end

    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= 1'b0;
      min_run_r    <= scss_pkg::MIN_RUN_RESET;
      warm_r       <= '0;
      cnt_r        <= '0;
      flush_r      <= 1'b0;
      rp_r         <= 1'b1;
      rl_r         <= scss_pkg::RUN_W'(scss_pkg::MIN_RUN_RESET);
      prl_r        <= '0;
      prev_r       <= '0;
      any_r        <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          scss_pkg::REG_ORDER_MODE: order_mode_r <= cfg_data[0];
          scss_pkg::REG_MIN_RUN:    min_run_r    <= cfg_data;
          default: ;
        endcase
      end
      warm_r      <= warm_nxt;
      cnt_r       <= cnt_nxt;
      flush_r     <= flush_nxt;
      rp_r        <= rp_nxt;
      rl_r        <= rl_nxt;
      prl_r       <= prl_nxt;
      prev_r      <= prev_nxt;
      any_r       <= any_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_index_r <= idx_r;
      out_slope_r <= head;
      out_down_r  <= any_r && (prev_r > 0) && (head < 0);
      out_up_r    <= any_r && (prev_r < 0) && (head > 0);
      out_end_r   <= pop && (cnt_r == CW'(1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_index        = out_index_r;
  assign out_slope        = out_slope_r;
  assign out_turn_down    = out_down_r;
  assign out_turn_up      = out_up_r;
  assign out_end_of_curve = out_end_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= HOLD_C)
    else $error("hold count beyond cell row");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cnt_r == CW'(1)) |=> (!flush_r && cnt_r == '0 && idx_r == '0 && !any_r))
    else $error("curve state not cleared after drain");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !in_last && !full) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("hold row did not grow on a new slope");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_down_r && out_up_r))
    else $error("both crossing flags set");

endmodule
